### rtl/core/bumsort_pkg.sv
// Shared types and constants for the bottom-up merge sorter.
// No dependencies; imported by the sequencer and the top level.
`default_nettype none

package bumsort_pkg;

	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SETUP,
		ST_MERGE,
		ST_PRIME,
		ST_SHOW
	} seq_state_t;

endpackage

`default_nettype wire

### rtl/core/bottom_up_merge_sorter_core.sv
// Bottom-up merge sorter top level: config register, two element banks, sequencer.
// Depends on bumsort_pkg, bumsort_ram and bumsort_seq.
//
// Collects signed 32-bit values, one per s_axis beat, until a beat with
// tlast; values beyond MAX_ITEMS are dropped and every result of that set
// then carries tuser = 1. The set is merge-sorted bottom up, ping-ponging
// between two memory banks, and streamed out on m_axis with tlast on the
// final value. s_axis_tready stays high while loading. Sorting of n values takes
// ceil(log2 n) passes; each pass writes all n values through the one write
// port of the other bank, and each run pair begins with a setup state.
// Output follows a prime state that reads the first value, and then moves
// one beat per cycle while m_axis_tready is high. No beat is taken on s_axis
// until the set is out. cfg_data[0] selects descending order and is sampled
// when the tlast beat is taken.
`default_nettype none

module bottom_up_merge_sorter_core #(
	parameter int MAX_ITEMS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_data,         // [0] descending
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,     // [31:0] value
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [31:0] m_axis_tdata,     // [31:0] sorted_value
	output logic             m_axis_tlast,
	output logic      [0:0]  m_axis_tuser      // [0] overflow
);

	import bumsort_pkg::*;

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

	logic              desc_q;
	logic              we0;
	logic              we1;
	logic [AW-1:0]     waddr;
	logic [DATA_W-1:0] wdata;
	logic [AW-1:0]     raddr_l;
	logic [AW-1:0]     raddr_r;
	logic [DATA_W-1:0] rd_l0;
	logic [DATA_W-1:0] rd_r0;
	logic [DATA_W-1:0] rd_l1;
	logic [DATA_W-1:0] rd_r1;
	logic              out_user;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q <= 1'b0;
		end else if (cfg_valid) begin
			desc_q <= cfg_data[0];
		end
	end

	bumsort_ram #(
		.DEPTH (MAX_ITEMS),
		.AW    (AW),
		.DW    (DATA_W)
	) u_bank0 (
		.clk     (clk),
		.we      (we0),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_l),
		.raddr_b (raddr_r),
		.rdata_a (rd_l0),
		.rdata_b (rd_r0)
	);

	bumsort_ram #(
		.DEPTH (MAX_ITEMS),
		.AW    (AW),
		.DW    (DATA_W)
	) u_bank1 (
		.clk     (clk),
		.we      (we1),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_l),
		.raddr_b (raddr_r),
		.rdata_a (rd_l1),
		.rdata_b (rd_r1)
	);

	bumsort_seq #(
		.MAX_ITEMS (MAX_ITEMS),
		.AW        (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.desc_cfg  (desc_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_user  (out_user),
		.we0       (we0),
		.we1       (we1),
		.waddr     (waddr),
		.wdata     (wdata),
		.raddr_l   (raddr_l),
		.raddr_r   (raddr_r),
		.rd_l0     (rd_l0),
		.rd_r0     (rd_r0),
		.rd_l1     (rd_l1),
		.rd_r1     (rd_r1)
	);

	assign m_axis_tuser = out_user;

endmodule

`default_nettype wire

### rtl/core/bumsort_ram.sv
// Element bank: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module bumsort_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 32
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr_a,
	input  wire logic [AW-1:0] raddr_b,
	output logic      [DW-1:0] rdata_a,
	output logic      [DW-1:0] rdata_b
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_a_q;
	logic [DW-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a_q <= mem[raddr_a];
		rdata_b_q <= mem[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

`default_nettype wire

### rtl/core/bumsort_seq.sv
// Load / merge / output sequencer of the merge sorter.
// Depends on bumsort_pkg; drives two external bumsort_ram banks.
`default_nettype none

module bumsort_seq #(
	parameter int MAX_ITEMS = 64,
	parameter int AW        = 6
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             desc_cfg,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [bumsort_pkg::DATA_W-1:0]   in_data,
	input  wire logic                             in_last,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic      [bumsort_pkg::DATA_W-1:0]   out_data,
	output logic                                  out_last,
	output logic                                  out_user,
	output logic                                  we0,
	output logic                                  we1,
	output logic      [AW-1:0]                    waddr,
	output logic      [bumsort_pkg::DATA_W-1:0]   wdata,
	output logic      [AW-1:0]                    raddr_l,
	output logic      [AW-1:0]                    raddr_r,
	input  wire logic [bumsort_pkg::DATA_W-1:0]   rd_l0,
	input  wire logic [bumsort_pkg::DATA_W-1:0]   rd_r0,
	input  wire logic [bumsort_pkg::DATA_W-1:0]   rd_l1,
	input  wire logic [bumsort_pkg::DATA_W-1:0]   rd_r1
);

	import bumsort_pkg::*;

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int XW = CW + 2;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	seq_state_t state_q, state_d;

	logic [CW-1:0] cnt_q;
	logic          drop_q;
	logic          desc_q;
	logic [CW-1:0] n_q;
	logic          src_q;
	logic [CW:0]   width_q;
	logic [CW-1:0] base_q;
	logic [CW-1:0] li_q;
	logic [CW-1:0] ri_q;
	logic [CW-1:0] lend_q;
	logic [CW-1:0] rend_q;
	logic [CW-1:0] dst_q;

	logic                has_room;
	logic [CW-1:0]       cnt_inc;
	logic [XW-1:0]       sum_l;
	logic [XW-1:0]       sum_r;
	logic [XW-1:0]       n_x;
	logic [CW-1:0]       setup_lend;
	logic [CW-1:0]       setup_rend;
	logic [DATA_W-1:0]   head_l;
	logic [DATA_W-1:0]   head_r;
	logic                lv;
	logic                rv;
	logic                before_r;
	logic                take_l;
	logic [CW-1:0]       li_n;
	logic [CW-1:0]       ri_n;
	logic [CW-1:0]       dst_inc;
	logic                pair_done;
	logic                more_pairs;
	logic [CW:0]         width_dbl;
	logic                more_passes;
	logic                show_last;

	assign has_room   = cnt_q < MAX_C;
	assign cnt_inc    = has_room ? cnt_q + ONE_C : cnt_q;
	assign sum_l      = XW'(base_q) + XW'(width_q);
	assign sum_r      = XW'(base_q) + (XW'(width_q) << 1);
	assign n_x        = XW'(n_q);
	assign setup_lend = (sum_l < n_x) ? sum_l[CW-1:0] : n_q;
	assign setup_rend = (sum_r < n_x) ? sum_r[CW-1:0] : n_q;

	// read data belongs to the bank that the current pass reads from
	assign head_l   = src_q ? rd_l1 : rd_l0;
	assign head_r   = src_q ? rd_r1 : rd_r0;
	assign lv       = li_q < lend_q;
	assign rv       = ri_q < rend_q;
	assign before_r = desc_q ? ($signed(head_l) > $signed(head_r))
	                         : ($signed(head_l) < $signed(head_r));
	// ties go to the right run
	assign take_l   = lv && (!rv || before_r);
	assign li_n     = li_q + CW'(take_l);
	assign ri_n     = ri_q + CW'(!take_l);
	assign dst_inc  = dst_q + ONE_C;

	assign pair_done   = dst_inc == rend_q;
	assign more_pairs  = sum_r < n_x;
	assign width_dbl   = width_q << 1;
	assign more_passes = width_dbl < (CW+1)'(n_q);
	assign show_last   = dst_inc == n_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_valid && in_last) begin
					state_d = (cnt_inc > ONE_C) ? ST_SETUP : ST_PRIME;
				end
			end
			ST_SETUP: begin
				state_d = ST_MERGE;
			end
			ST_MERGE: begin
				if (pair_done) begin
					state_d = (more_pairs || more_passes) ? ST_SETUP : ST_PRIME;
				end
			end
			ST_PRIME: begin
				state_d = ST_SHOW;
			end
			ST_SHOW: begin
				if (out_ready && show_last) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// Merges read one bank and write the other, so no read-after-write
	// hazard exists inside a pass.
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		out_data  = head_l;
		out_last  = show_last;
		out_user  = drop_q;
		we0       = 1'b0;
		we1       = 1'b0;
		waddr     = dst_q[AW-1:0];
		wdata     = take_l ? head_l : head_r;
		raddr_l   = li_q[AW-1:0];
		raddr_r   = ri_q[AW-1:0];
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				we0      = in_valid && has_room;
				waddr    = cnt_q[AW-1:0];
				wdata    = in_data;
			end
			ST_SETUP: begin
				raddr_l = base_q[AW-1:0];
				raddr_r = setup_lend[AW-1:0];
			end
			ST_MERGE: begin
				we0     = src_q;
				we1     = !src_q;
				raddr_l = li_n[AW-1:0];
				raddr_r = ri_n[AW-1:0];
			end
			ST_PRIME: begin
				raddr_l = dst_q[AW-1:0];
			end
			ST_SHOW: begin
				out_valid = 1'b1;
				// hold the address while stalled so the beat stays put
				raddr_l   = out_ready ? dst_inc[AW-1:0] : dst_q[AW-1:0];
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			drop_q  <= 1'b0;
			desc_q  <= 1'b0;
			n_q     <= '0;
			src_q   <= 1'b0;
			width_q <= '0;
			base_q  <= '0;
			li_q    <= '0;
			ri_q    <= '0;
			lend_q  <= '0;
			rend_q  <= '0;
			dst_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: begin
					if (in_valid) begin
						cnt_q <= cnt_inc;
						if (!has_room) begin
							drop_q <= 1'b1;
						end
						if (in_last) begin
							n_q     <= cnt_inc;
							desc_q  <= desc_cfg;
							src_q   <= 1'b0;
							width_q <= (CW+1)'(1);
							base_q  <= '0;
							dst_q   <= '0;
						end
					end
				end
				ST_SETUP: begin
					li_q   <= base_q;
					ri_q   <= setup_lend;
					lend_q <= setup_lend;
					rend_q <= setup_rend;
					dst_q  <= base_q;
				end
				ST_MERGE: begin
					li_q  <= li_n;
					ri_q  <= ri_n;
					dst_q <= dst_inc;
					if (pair_done) begin
						if (more_pairs) begin
							base_q <= sum_r[CW-1:0];
						end else begin
							// pass done: swap banks, double the run width
							src_q   <= !src_q;
							width_q <= width_dbl;
							base_q  <= '0;
							dst_q   <= '0;
						end
					end
				end
				ST_PRIME: begin
					dst_q <= dst_q;
				end
				ST_SHOW: begin
					if (out_ready) begin
						dst_q <= dst_inc;
						if (show_last) begin
							cnt_q  <= '0;
							drop_q <= 1'b0;
						end
					end
				end
				default: begin
					dst_q <= dst_q;
				end
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output open at once");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_C)
		else $error("element count beyond capacity");

	a_merge_dst: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> (dst_q < n_q) && (dst_q < rend_q))
		else $error("merge write outside the set");

	a_merge_src: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> (lv || rv))
		else $error("merge step with both runs empty");

	a_show_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_data))
		else $error("stalled result changed");

endmodule

`default_nettype wire

### dv/sort_result_checker.sv
// Checker for bottom_up_merge_sorter_core: watches the config, input and output channels,
// predicts each sorted set and compares every output beat with it.
// Depends on bumsort_pkg for the data width.
module sort_result_checker #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [0:0]                     cfg_data,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [bumsort_pkg::DATA_W-1:0] s_axis_tdata,
	input  logic                           s_axis_tlast,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [bumsort_pkg::DATA_W-1:0] m_axis_tdata,
	input  logic                           m_axis_tlast,
	input  logic [0:0]                     m_axis_tuser,
	output int                             errors,
	output int                             pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import bumsort_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              final_beat;
		logic              overflow;
	} sorted_beat_t;

	logic [DATA_W-1:0] loaded_set [MAX_ITEMS];
	int                loaded_count;
	logic              set_overflowed;
	logic              order_desc;
	sorted_beat_t      sorted_due_q [$];

	task automatic report(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		$display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
		errors++;
	endtask

	function automatic bit precedes(input logic signed [DATA_W-1:0] a,
			input logic signed [DATA_W-1:0] b);
		return order_desc ? (a > b) : (a < b);
	endfunction

	// Equal values are interchangeable, so a stable insertion sort yields the same
	// beats as the merge passes of the block.
	function automatic void queue_sorted_set();
		logic signed [DATA_W-1:0] work [MAX_ITEMS];
		logic signed [DATA_W-1:0] key;
		int                       j;
		sorted_beat_t             beat;
		for (int i = 0; i < loaded_count; i++)
			work[i] = loaded_set[i];
		for (int i = 1; i < loaded_count; i++) begin
			key = work[i];
			j = i;
			while (j > 0 && precedes(key, work[j-1])) begin
				work[j] = work[j-1];
				j--;
			end
			work[j] = key;
		end
		for (int i = 0; i < loaded_count; i++) begin
			beat.value = work[i];
			beat.final_beat = (i == loaded_count - 1);
			beat.overflow = set_overflowed;
			sorted_due_q.push_back(beat);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sorted_beat_t due;
		if (!arst_n) begin
			loaded_count = 0;
			set_overflowed = 1'b0;
			order_desc = 1'b0;
			sorted_due_q.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				order_desc = cfg_data[0];
			if (m_axis_tvalid && m_axis_tready) begin
				if (sorted_due_q.size() == 0) begin
					report("unexpected output beat", m_axis_tdata, '0);
				end else begin
					due = sorted_due_q.pop_front();
					if (m_axis_tdata !== due.value)
						report("sorted value", m_axis_tdata, due.value);
					if (m_axis_tlast !== due.final_beat)
						report("tlast", DATA_W'(m_axis_tlast), DATA_W'(due.final_beat));
					if (m_axis_tuser[0] !== due.overflow)
						report("overflow flag", DATA_W'(m_axis_tuser), DATA_W'(due.overflow));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				// drop anything past capacity, the tlast beat included
				if (loaded_count < MAX_ITEMS) begin
					loaded_set[loaded_count] = s_axis_tdata;
					loaded_count++;
				end else begin
					set_overflowed = 1'b1;
				end
				if (s_axis_tlast) begin
					queue_sorted_set();
					loaded_count = 0;
					set_overflowed = 1'b0;
				end
			end
		end
		pending = sorted_due_q.size();
	end

endmodule

### dv/testbench.sv
// Top of the sorter testbench: clock, reset, stimulus, output stalls and the verdict.
// Depends on bumsort_pkg, bottom_up_merge_sorter_core and sort_result_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bumsort_pkg::*;

	localparam int MAX_ITEMS    = 64;
	localparam int STALL_LIMIT  = 4000;
	localparam int RANDOM_ITEMS = 180;

	logic              clk;
	logic              arst_n        = 1'b0;
	logic              cfg_valid     = 1'b0;
	logic              cfg_ready;
	logic [0:0]        cfg_data      = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata  = '0;
	logic              s_axis_tlast  = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata;
	logic              m_axis_tlast;
	logic [0:0]        m_axis_tuser;
	int                errors;
	int                pending;

	localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
	localparam logic [DATA_W-1:0] MOST_POS = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] MINUS_1  = 32'hFFFF_FFFF;

	bottom_up_merge_sorter_core #(.MAX_ITEMS(MAX_ITEMS)) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	sort_result_checker #(.MAX_ITEMS(MAX_ITEMS)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.errors        (errors),
		.pending       (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Output side: switch between free flow, random and heavy stall patterns.
	int rx_mode = 0;
	int rx_left = 0;
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(16, 96);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= (rx_left % 12) < 4;
		endcase
	end

	// Abort when no beat moves on any channel for too long.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("** bottom_up_merge_sorter_core: FAILED **");
			$finish;
		end
	end

	bit gaps_on   = 1'b0;
	int burst_left = 0;

	task automatic send_beat(input logic [DATA_W-1:0] value, input logic last_beat);
		s_axis_tdata  <= value;
		s_axis_tlast  <= last_beat;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 7);
			if (gaps_on) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
		end
	endtask

	task automatic send_list(input logic [DATA_W-1:0] values [$]);
		foreach (values[i])
			send_beat(values[i], i == values.size() - 1);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 4))
			0: return DATA_W'($signed($urandom_range(0, 7)) - 4);
			1: begin
				case ($urandom_range(0, 3))
					0: return MOST_NEG;
					1: return MOST_POS;
					2: return '0;
					default: return MINUS_1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random_set(input int count);
		for (int i = 0; i < count; i++)
			send_beat(pick_value(), i == count - 1);
	endtask

	// Hold the input until every predicted beat is out, then let the block settle.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_order(input logic desc);
		cfg_data  <= desc;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [DATA_W-1:0] extremes [$];
		int                random_sent;
		int                round;
		int                count;
		extremes = '{MOST_POS, MOST_NEG, 32'h0, MINUS_1, 32'h1, MOST_POS};
		random_sent = 0;
		round = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_order(1'b0);
		send_list('{MOST_NEG});
		send_list(extremes);
		send_list('{32'd5, 32'd5, 32'hFFFF_FFFB, 32'd5});
		drain();
		write_order(1'b1);
		send_list(extremes);
		send_list('{MOST_POS});
		send_list('{32'd3, 32'd3});

		while (random_sent < RANDOM_ITEMS) begin
			drain();
			write_order(1'($urandom_range(0, 1)));
			gaps_on = ($urandom_range(0, 3) != 0);
			// full store, then an overrun that drops the tlast beat as well
			case (round)
				0: begin
					send_random_set(MAX_ITEMS);
					random_sent += MAX_ITEMS;
				end
				1: begin
					send_random_set(MAX_ITEMS + 2);
					random_sent += MAX_ITEMS + 2;
				end
				default: ;
			endcase
			repeat ($urandom_range(1, 4)) begin
				count = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) :
					$urandom_range(1, 12);
				send_random_set(count);
				random_sent += count;
			end
			round++;
		end

		drain();
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("** bottom_up_merge_sorter_core: PASSED **");
		else
			$display("** bottom_up_merge_sorter_core: FAILED **");
		$finish;
	end

endmodule
